// ===== hdl/smfc_pkg.sv =====
// Shared types, register codes and CS bit positions of the SPI master.
package smfc_pkg;

   localparam int FifoDepthDefault = 64;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_SHIFT = 2'd2,
      KIND_IDLE  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      REG_CS   = 3'd0,
      REG_FIFO = 3'd1,
      REG_CLK  = 3'd2,
      REG_DLEN = 3'd3,
      REG_LTOH = 3'd4,
      REG_DC   = 3'd5,
      REG_BAD6 = 3'd6,
      REG_BAD7 = 3'd7
   } reg_type;

   localparam int BCLRTX = 4;
   localparam int BCLRRX = 5;
   localparam int BCSPOL = 6;
   localparam int BTA    = 7;
   localparam int BDMAEN = 8;
   localparam int BINTD  = 9;
   localparam int BINTR  = 10;
   localparam int BADCS  = 11;
   localparam int BDONE  = 16;
   localparam int BRXD   = 17;
   localparam int BTXD   = 18;
   localparam int BRXR   = 19;
   localparam int BRXF   = 20;
   localparam int BCSPOL0 = 21;

   localparam logic [31:0] CS_RESET  = 32'h0004_1000;
   localparam logic [31:0] CS_RO     = 32'h001F_0000;
   localparam logic [31:0] DC_RESET  = 32'h3020_1020;

   // controller -> datapath command
   typedef struct packed {
      logic       load;      // latch the request into the datapath
      logic       finish;    // present the finished result
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic       busy_more; // another byte lane remains in the current transaction
   } stat_type;

endpackage

// ===== hdl/smfc_ram.sv =====
// Generic single-port write, single-port registered-read RAM.
module smfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== hdl/smfc_ctrl.sv =====
// Controller state machine: sequences accept, byte lanes and result hand-off.
module smfc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  smfc_pkg::stat_type stat,
   output smfc_pkg::cmd_type  cmd
);
   import smfc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WORK = 3'b010,
      ST_OUT  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   // Output holds while downstream stalls; a new transaction enters once it drains.
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign accept     = req_tvalid && req_tready;
   assign cmd.load   = accept;
   assign cmd.finish = (state_ff == ST_WORK) && !stat.busy_more;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_WORK;
         ST_WORK: if (!stat.busy_more) state_in = ST_OUT;
         ST_OUT:  if (rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule

// ===== hdl/smfc_dp.sv =====
// Datapath: registers, both FIFOs, byte-lane sequencing and output levels.
module smfc_dp #(
   parameter int FIFO_DEPTH = smfc_pkg::FifoDepthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  smfc_pkg::cmd_type  cmd,
   output smfc_pkg::stat_type stat,
   input  logic [1:0]         in_kind,
   input  logic [2:0]         in_reg,
   input  logic [31:0]        in_wdata,
   input  logic [7:0]         in_miso,
   output logic [31:0]        read_data,
   output logic [7:0]         mosi_byte,
   output logic               mosi_valid,
   output logic               irq,
   output logic [2:0]         chip_selects,
   output logic               tx_dma_request,
   output logic               rx_dma_request,
   output logic               tx_dma_panic,
   output logic               rx_dma_panic,
   output logic               bad_offset
);
   import smfc_pkg::*;

   localparam int AW = $clog2(FIFO_DEPTH);
   localparam int CW = $clog2(FIFO_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);
   localparam logic [CW-1:0] RXR_C   = CW'((FIFO_DEPTH * 3) / 4);

   // architectural state
   logic [31:0] cs_ff, cs_in;
   logic [15:0] clkdiv_ff, clkdiv_in, dlen_ff, dlen_in, left_ff, left_in;
   logic [3:0]  ltoh_ff, ltoh_in;
   logic [31:0] dc_ff, dc_in;
   logic        fin_ff, fin_in;
   logic [AW-1:0] th_ff, th_in, rh_ff, rh_in;
   logic [CW-1:0] tc_ff, tc_in, rc_ff, rc_in;

   // transaction registers
   logic [1:0]  kind_ff;
   logic [2:0]  reg_ff;
   logic [31:0] wd_ff;
   logic [7:0]  miso_ff;
   logic [1:0]  lane_ff, lane_in;
   logic        go_ff, go_in;         // lanes still running
   logic [31:0] rd_ff, rd_in;
   logic [7:0]  mo_ff, mo_in;
   logic        mv_ff, mv_in;

   // RAM ports
   logic          tx_we, rx_we;
   logic [AW-1:0] tx_wa, rx_wa;
   logic [7:0]    tx_wd, rx_wd, tx_rd, rx_rd;
   logic [AW-1:0] tx_ra, rx_ra;

   smfc_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_txram (
      .clock, .wr_en(tx_we), .wr_addr(tx_wa), .wr_data(tx_wd),
      .rd_addr(tx_ra), .rd_data(tx_rd));
   smfc_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_rxram (
      .clock, .wr_en(rx_we), .wr_addr(rx_wa), .wr_data(rx_wd),
      .rd_addr(rx_ra), .rd_data(rx_rd));

   // read addresses are set up in the cycle before use so the registered data is ready
   assign tx_ra = cmd.load ? th_ff : th_in;
   assign rx_ra = cmd.load ? rh_ff : rh_in;

   assign stat.busy_more = go_ff;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                              input logic [CW-1:0] b);
      logic [CW:0] s;
      s = {1'b0, CW'(a)} + {1'b0, b};
      if (s >= (CW+1)'(FIFO_DEPTH)) s = s - (CW+1)'(FIFO_DEPTH);
      return s[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] inc(input logic [AW-1:0] a);
      return wrap_add(a, CW'(1));
   endfunction

   always_comb begin
      logic        dma, ta, old_ta, ok;
      logic [31:0] v;
      cs_in = cs_ff; clkdiv_in = clkdiv_ff; dlen_in = dlen_ff; left_in = left_ff;
      ltoh_in = ltoh_ff; dc_in = dc_ff; fin_in = fin_ff;
      th_in = th_ff; tc_in = tc_ff; rh_in = rh_ff; rc_in = rc_ff;
      lane_in = lane_ff; go_in = go_ff;
      rd_in = rd_ff; mo_in = mo_ff; mv_in = mv_ff;
      tx_we = 1'b0; rx_we = 1'b0;
      tx_wa = wrap_add(th_ff, tc_ff); tx_wd = wd_ff[8*lane_ff +: 8];
      rx_wa = wrap_add(rh_ff, rc_ff); rx_wd = miso_ff;
      dma = cs_ff[BDMAEN]; ta = cs_ff[BTA]; old_ta = ta; v = wd_ff;
      ok = 1'b0;

      if (go_ff) begin
         go_in = 1'b0;
         if (kind_ff == KIND_READ && reg_ff == REG_FIFO) begin
            if (dma) begin
               if (rc_ff != '0) begin
                  rd_in[8*lane_ff +: 8] = rx_rd;
                  rh_in = inc(rh_ff); rc_in = rc_ff - CW'(1);
                  if (lane_ff != 2'd3 && rc_ff != CW'(1)) begin
                     go_in = 1'b1; lane_in = lane_ff + 2'd1;
                  end
               end
            end else if (cs_ff[BRXD]) begin
               rd_in = {24'd0, rx_rd};
               rh_in = inc(rh_ff); rc_in = rc_ff - CW'(1);
            end
            if (!go_in && cs_ff[BRXD]) begin
               cs_in[BRXD] = rc_in != '0;
               cs_in[BRXF] = rc_in >= DEPTH_C;
               cs_in[BRXR] = rc_in >= RXR_C;
            end
         end else if (kind_ff == KIND_READ) begin
            unique case (reg_type'(reg_ff))
               REG_CS:   rd_in = cs_ff;
               REG_CLK:  rd_in = {16'd0, clkdiv_ff};
               REG_DLEN: rd_in = {16'd0, dlen_ff};
               REG_LTOH: rd_in = {28'd0, ltoh_ff};
               REG_DC:   rd_in = dc_ff;
               default:  rd_in = '0;
            endcase
         end else if (kind_ff == KIND_WRITE) begin
            unique case (reg_type'(reg_ff))
               REG_CS: begin
                  cs_in = (v & ~CS_RO) | (cs_ff & CS_RO);
                  if (!cs_in[BTA]) begin
                     cs_in[BDONE] = 1'b0; cs_in[BRXR] = 1'b0;
                     left_in = '0; fin_in = 1'b0;
                  end
                  if (cs_in[BCLRRX]) begin
                     rh_in = '0; rc_in = '0;
                     cs_in[BRXD] = 1'b0; cs_in[BRXF] = 1'b0; cs_in[BRXR] = 1'b0;
                  end
                  if (cs_in[BCLRTX]) begin
                     th_in = '0; tc_in = '0;
                     cs_in[BTXD] = 1'b1;
                     cs_in[BDONE] = cs_in[BTA] && (!cs_in[BDMAEN] || fin_in);
                  end
                  cs_in[BCLRRX] = 1'b0; cs_in[BCLRTX] = 1'b0;
                  if (cs_in[BTA]) begin
                     if (!old_ta && cs_in[BDMAEN]) begin
                        left_in = dlen_ff; fin_in = dlen_ff == '0;
                     end
                     cs_in[BTXD] = tc_in < DEPTH_C;
                     cs_in[BDONE] = tc_in == '0 && (!cs_in[BDMAEN] || fin_in);
                  end
               end
               REG_FIFO: begin
                  if (dma && !ta) begin
                     dlen_in = v[31:16];
                     cs_in[7:0] = v[7:0];
                     if (cs_in[BCLRRX]) begin rh_in = '0; rc_in = '0; end
                     if (cs_in[BCLRTX]) begin th_in = '0; tc_in = '0; end
                     cs_in[BCLRRX] = 1'b0; cs_in[BCLRTX] = 1'b0;
                     left_in = v[31:16]; fin_in = v[31:16] == '0;
                     cs_in[BRXD] = rc_in != '0;
                     cs_in[BRXF] = rc_in >= DEPTH_C;
                     cs_in[BRXR] = rc_in >= RXR_C;
                     cs_in[BTXD] = tc_in < DEPTH_C;
                     cs_in[BDONE] = tc_in == '0 && cs_in[BTA] &&
                                    (!cs_in[BDMAEN] || fin_in);
                  end else if (ta && cs_ff[BTXD]) begin
                     ok = tc_ff < DEPTH_C &&
                          (!dma || 16'(tc_ff) < left_ff);
                     if (ok) begin
                        tx_we = 1'b1; tc_in = tc_ff + CW'(1);
                        if (dma && lane_ff != 2'd3) begin
                           go_in = 1'b1; lane_in = lane_ff + 2'd1;
                        end
                     end
                     if (!go_in) begin
                        cs_in[BTXD] = tc_in < DEPTH_C;
                        cs_in[BDONE] = tc_in == '0 && ta && (!dma || fin_ff);
                     end
                  end
               end
               REG_CLK:  clkdiv_in = v[15:0];
               REG_DLEN: begin
                  dlen_in = v[15:0];
                  if (dma && ta) begin
                     left_in = v[15:0]; fin_in = v[15:0] == '0;
                     cs_in[BTXD] = tc_ff < DEPTH_C;
                     cs_in[BDONE] = tc_ff == '0 && fin_in;
                  end
               end
               REG_LTOH: ltoh_in = v[3:0];
               REG_DC:   dc_in = v;
               default: ;
            endcase
         end else if (kind_ff == KIND_SHIFT) begin
            if (ta && tc_ff != '0 && rc_ff < DEPTH_C && (!dma || left_ff != '0)) begin
               mo_in = tx_rd; mv_in = 1'b1;
               th_in = inc(th_ff); tc_in = tc_ff - CW'(1);
               rx_we = 1'b1; rc_in = rc_ff + CW'(1);
               if (dma) begin
                  left_in = left_ff - 16'd1;
                  if (left_in == '0) fin_in = 1'b1;
               end
            end
            cs_in[BTXD] = tc_in < DEPTH_C;
            cs_in[BDONE] = tc_in == '0 && ta && (!dma || fin_in);
            cs_in[BRXD] = rc_in != '0;
            cs_in[BRXF] = rc_in >= DEPTH_C;
            cs_in[BRXR] = rc_in >= RXR_C;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cs_ff <= CS_RESET; clkdiv_ff <= '0; dlen_ff <= '0; left_ff <= '0;
         ltoh_ff <= 4'd1; dc_ff <= DC_RESET; fin_ff <= 1'b0;
         th_ff <= '0; tc_ff <= '0; rh_ff <= '0; rc_ff <= '0;
         go_ff <= 1'b0;
      end else begin
         cs_ff <= cs_in; clkdiv_ff <= clkdiv_in; dlen_ff <= dlen_in; left_ff <= left_in;
         ltoh_ff <= ltoh_in; dc_ff <= dc_in; fin_ff <= fin_in;
         th_ff <= th_in; tc_ff <= tc_in; rh_ff <= rh_in; rc_ff <= rc_in;
         go_ff <= cmd.load ? 1'b1 : go_in;
      end
   end

   // transaction payload: latched on accept, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= in_kind; reg_ff <= in_reg; wd_ff <= in_wdata; miso_ff <= in_miso;
         lane_ff <= 2'd0; rd_ff <= '0; mo_ff <= '0; mv_ff <= 1'b0;
      end else begin
         lane_ff <= lane_in; rd_ff <= rd_in; mo_ff <= mo_in; mv_ff <= mv_in;
      end
   end

   // levels from the settled state
   logic       csact, bad;
   logic [7:0] tdt, tpt, rqt, rpt;
   assign bad   = (kind_ff == KIND_READ || kind_ff == KIND_WRITE) &&
                  (reg_ff == REG_BAD6 || reg_ff == REG_BAD7);
   assign csact = cs_ff[BTA] && (!cs_ff[BDMAEN] || !cs_ff[BADCS] || !fin_ff);
   assign tdt = dc_ff[7:0];
   assign tpt = dc_ff[15:8];
   assign rqt = dc_ff[23:16];
   assign rpt = dc_ff[31:24];

   always_comb begin
      logic hi, act;
      for (int i = 0; i < 3; i++) begin
         hi  = cs_ff[BCSPOL] || cs_ff[BCSPOL0 + i];
         act = (cs_ff[1:0] == 2'(i)) && csact;
         chip_selects[i] = act ? hi : !hi;
      end
   end

   assign read_data  = rd_ff;
   assign mosi_byte  = mo_ff;
   assign mosi_valid = mv_ff;
   assign bad_offset = bad;
   assign irq = (cs_ff[BINTD] && cs_ff[BDONE]) || (cs_ff[BINTR] && cs_ff[BRXR]);
   assign tx_dma_request = cs_ff[BDMAEN] &&
      (!cs_ff[BTA] || (left_ff != '0 && 16'(tc_ff) <= 16'(tdt)));
   assign tx_dma_panic = cs_ff[BDMAEN] &&
      (!cs_ff[BTA] || left_ff != '0) && 16'(tc_ff) <= 16'(tpt);
   assign rx_dma_request = cs_ff[BDMAEN] && rc_ff != '0 &&
      (16'(rc_ff) > 16'(rqt) || fin_ff);
   assign rx_dma_panic = cs_ff[BDMAEN] && 16'(rc_ff) > 16'(rpt);
endmodule

// ===== hdl/spi_master_fifo_controller.sv =====
// Top level of the register-mapped SPI master with transmit and receive FIFOs.
//
// Request channel (req_*): one transaction is a bus read, a bus write, an idle or one
// serial byte time (kind in tuser). The block answers each transaction with
// exactly one response on rsp_*: read data, the byte shifted out, and the
// interrupt, chip-select and DMA levels as they stand after that transaction.
// Sequence: accept, then the FIFO byte lanes in turn (one, or up to four for
// DMA FIFO accesses), then the response is presented. The byte-lane sequencer
// over the single FIFO RAM port sets how long a transaction takes.
// The response register holds while rsp_tready is low; no new request is
// taken until the response has gone.
// Reset (synchronous, active high) restores the architectural registers: CS = TXD|REN,
// LTOH = 1, DC = 0x30201020, both FIFOs empty. No clearing pass is needed.
module spi_master_fifo_controller #(
   parameter int FIFO_DEPTH = smfc_pkg::FifoDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // reg_index[2:0], write_data[34:3], miso_byte[42:35]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[31:0], mosi_byte[39:32], mosi_valid[40], irq[41],
   // chip_selects[44:42], tx_dma_request[45], rx_dma_request[46],
   // tx_dma_panic[47], rx_dma_panic[48], bad_offset[49]
   output logic [55:0] rsp_tdata
);
   import smfc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   smfc_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .stat, .cmd);

   assign rsp_tdata[55:50] = '0;

   smfc_dp #(.FIFO_DEPTH(FIFO_DEPTH)) u_dp (
      .clock, .reset, .cmd, .stat,
      .in_kind(req_tuser), .in_reg(req_tdata[2:0]), .in_wdata(req_tdata[34:3]),
      .in_miso(req_tdata[42:35]),
      .read_data(rsp_tdata[31:0]), .mosi_byte(rsp_tdata[39:32]),
      .mosi_valid(rsp_tdata[40]), .irq(rsp_tdata[41]),
      .chip_selects(rsp_tdata[44:42]), .tx_dma_request(rsp_tdata[45]),
      .rx_dma_request(rsp_tdata[46]), .tx_dma_panic(rsp_tdata[47]),
      .rx_dma_panic(rsp_tdata[48]), .bad_offset(rsp_tdata[49]));

   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("request and response overlap");
   a_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("double accept");
   a_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_tvalid) else $error("finished work not presented");
endmodule
